// File: rtl/wsma_pkg.sv
// Shared constants, codes and beat types for the wheel speed meter.
// No dependencies; every rtl file imports this package.
package wsma_pkg;

   // Averaging window and field widths
   localparam int WINDOW_LEN = 9;
   localparam int CNT_W      = 9;
   localparam int ENTRY_W    = CNT_W + 1;
   localparam int OUT_W      = 14;
   localparam int SUM_W      = ENTRY_W + $clog2(WINDOW_LEN);
   localparam int POS_W      = $clog2(WINDOW_LEN);

   localparam logic [CNT_W-1:0] CLAMP_RESET = CNT_W'(500);

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // Event codes on the request mode field
   typedef enum logic [1:0] {
      MODE_LEFT  = 2'd0,
      MODE_RIGHT = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   // Registered request beat
   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
      logic       left_dir;
      logic       right_dir;
   } item_type;

   // Running window sums, flagged when a tick just updated them
   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] left_sum;
      logic signed [SUM_W-1:0] right_sum;
   } sums_type;

   // One result beat
   typedef struct packed {
      logic signed [OUT_W-1:0] speed_left;
      logic signed [OUT_W-1:0] speed_right;
      logic signed [OUT_W-1:0] speed_mean;
   } result_type;

endpackage

// File: rtl/wsma_window.sv
// Pulse counters, clamp register, sample windows and running sums.
// Depends on wsma_pkg.
module wsma_window import wsma_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   input  item_type         item,
   output sums_type         sums
);

   logic [CNT_W-1:0] clamp_ff;
   logic [CNT_W-1:0] left_cnt_ff, left_cnt_in;
   logic [CNT_W-1:0] right_cnt_ff, right_cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic signed [ENTRY_W-1:0] left_win_ff [WINDOW_LEN];
   logic signed [ENTRY_W-1:0] right_win_ff [WINDOW_LEN];
   logic signed [SUM_W-1:0] left_sum_ff, left_sum_in;
   logic signed [SUM_W-1:0] right_sum_ff, right_sum_in;
   logic sums_valid_ff;

   logic is_tick;
   logic [CNT_W-1:0] left_clip, right_clip;
   logic signed [ENTRY_W-1:0] left_mag, right_mag;
   logic signed [ENTRY_W-1:0] left_val, right_val;

   // Clip counts and apply the direction signs
   always_comb begin
      is_tick    = item.valid && (item.mode == MODE_TICK);
      left_clip  = (left_cnt_ff < clamp_ff) ? left_cnt_ff : clamp_ff;
      right_clip = (right_cnt_ff < clamp_ff) ? right_cnt_ff : clamp_ff;
      left_mag   = signed'({1'b0, left_clip});
      right_mag  = signed'({1'b0, right_clip});
      left_val   = item.left_dir ? left_mag : -left_mag;
      right_val  = item.right_dir ? -right_mag : right_mag;
   end

   // Replace the oldest entry in each running sum
   always_comb begin
      left_sum_in  = left_sum_ff + SUM_W'(left_val) - SUM_W'(left_win_ff[pos_ff]);
      right_sum_in = right_sum_ff + SUM_W'(right_val) - SUM_W'(right_win_ff[pos_ff]);
      pos_in       = (pos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;
   end

   // Count pulses up to the clamp, clear on tick
   always_comb begin
      left_cnt_in  = left_cnt_ff;
      right_cnt_in = right_cnt_ff;
      if (item.valid) begin
         case (item.mode)
            MODE_LEFT: begin
               left_cnt_in = (left_cnt_ff < clamp_ff) ? left_cnt_ff + 1'b1 : clamp_ff;
            end
            MODE_RIGHT: begin
               right_cnt_in = (right_cnt_ff < clamp_ff) ? right_cnt_ff + 1'b1 : clamp_ff;
            end
            MODE_TICK: begin
               left_cnt_in  = '0;
               right_cnt_in = '0;
            end
            default: begin
               left_cnt_in  = left_cnt_ff;
               right_cnt_in = right_cnt_ff;
            end
         endcase
      end
   end

   // Hold clamp limit
   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= CLAMP_RESET;
      end else if (csr_wr_en) begin
         clamp_ff <= csr_wr_data;
      end
   end

   // Advance counters, windows and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         left_cnt_ff   <= '0;
         right_cnt_ff  <= '0;
         pos_ff        <= '0;
         left_win_ff   <= '{default: '0};
         right_win_ff  <= '{default: '0};
         left_sum_ff   <= '0;
         right_sum_ff  <= '0;
         sums_valid_ff <= 1'b0;
      end else begin
         left_cnt_ff   <= left_cnt_in;
         right_cnt_ff  <= right_cnt_in;
         sums_valid_ff <= is_tick;
         if (is_tick) begin
            left_win_ff[pos_ff]  <= left_val;
            right_win_ff[pos_ff] <= right_val;
            left_sum_ff          <= left_sum_in;
            right_sum_ff         <= right_sum_in;
            pos_ff               <= pos_in;
         end
      end
   end

   assign sums.valid     = sums_valid_ff;
   assign sums.left_sum  = left_sum_ff;
   assign sums.right_sum = right_sum_ff;

endmodule

// File: rtl/wsma_scale.sv
// Q4 window means: rounded division of the sums by constant divisors.
// Depends on wsma_pkg; division is a multiply by a reciprocal.
module wsma_scale import wsma_pkg::*; (
   input  sums_type   sums,
   output result_type result
);

   localparam int NUM_W   = SUM_W + 5;
   localparam int SHIFT_1 = NUM_W + $clog2(WINDOW_LEN);
   localparam int SHIFT_2 = NUM_W + $clog2(2 * WINDOW_LEN);
   localparam int PROD1_W = NUM_W + SHIFT_1;
   localparam int PROD2_W = NUM_W + SHIFT_2;
   localparam longint RECIP_1 = ((longint'(1) << SHIFT_1) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam longint RECIP_2 =
      ((longint'(1) << SHIFT_2) + 2 * WINDOW_LEN - 1) / (2 * WINDOW_LEN);

   logic signed [SUM_W:0] both_sum;
   logic [SUM_W-1:0] left_abs, right_abs;
   logic [SUM_W:0]   both_abs;
   logic [NUM_W-1:0] left_num, right_num, both_num;
   logic [PROD1_W-1:0] left_prod, right_prod;
   logic [PROD2_W-1:0] both_prod;
   logic [OUT_W-1:0] left_q, right_q, both_q;

   // Take magnitudes and add the rounding half
   always_comb begin
      both_sum  = {sums.left_sum[SUM_W-1], sums.left_sum}
                + {sums.right_sum[SUM_W-1], sums.right_sum};
      left_abs  = sums.left_sum[SUM_W-1] ? SUM_W'(-sums.left_sum) : SUM_W'(sums.left_sum);
      right_abs = sums.right_sum[SUM_W-1] ? SUM_W'(-sums.right_sum) : SUM_W'(sums.right_sum);
      both_abs  = both_sum[SUM_W] ? (SUM_W + 1)'(-both_sum) : (SUM_W + 1)'(both_sum);
      left_num  = NUM_W'({left_abs, 4'b0000}) + NUM_W'(WINDOW_LEN / 2);
      right_num = NUM_W'({right_abs, 4'b0000}) + NUM_W'(WINDOW_LEN / 2);
      both_num  = NUM_W'({both_abs, 4'b0000}) + NUM_W'(WINDOW_LEN);
   end

   // Divide by reciprocal multiply, exact over the numerator range
   always_comb begin
      left_prod  = PROD1_W'(left_num) * PROD1_W'(RECIP_1);
      right_prod = PROD1_W'(right_num) * PROD1_W'(RECIP_1);
      both_prod  = PROD2_W'(both_num) * PROD2_W'(RECIP_2);
      left_q     = left_prod[SHIFT_1 +: OUT_W];
      right_q    = right_prod[SHIFT_1 +: OUT_W];
      both_q     = both_prod[SHIFT_2 +: OUT_W];
   end

   // Restore signs, ties round away from zero
   always_comb begin
      result.speed_left  = sums.left_sum[SUM_W-1] ? -left_q : left_q;
      result.speed_right = sums.right_sum[SUM_W-1] ? -right_q : right_q;
      result.speed_mean  = both_sum[SUM_W] ? -both_q : both_q;
   end

endmodule

// File: rtl/wsma_fifo.sv
// Result queue that decouples the result channel from the pipeline.
// Depends on wsma_pkg.
module wsma_fifo import wsma_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  result_type            push_data,
   input  logic                  pop,
   output result_type            head,
   output logic [FIFO_CNT_W-1:0] count
);

   result_type mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store result beats
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// File: rtl/wheel_speed_moving_average.sv
// Two-wheel encoder speed meter, top level. An accepted tick goes through the
// request register, the window sum registers and then the result queue.
// Throughput: one request beat per cycle while req_ready is high, set by the
// single-pass update stage; req_ready falls so ticks in flight never overfill
// the four-deep result queue, which holds beats while rsp_ready is low.
// Reset (synchronous) clears counters, windows and sums at once, sets the
// clamp limit to 500 and empties the queue.
module wheel_speed_moving_average import wsma_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CNT_W-1:0]        csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_mode,
   input  logic                    req_left_dir,
   input  logic                    req_right_dir,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_speed_left,
   output logic signed [OUT_W-1:0] rsp_speed_right,
   output logic signed [OUT_W-1:0] rsp_speed_mean
);

   item_type   item_ff;
   sums_type   sums;
   result_type result;
   result_type head;
   logic [FIFO_CNT_W-1:0] count;
   logic [FIFO_CNT_W:0]   pending;
   logic req_beat, rsp_beat;

   // Admit a beat only while every tick in flight has a queue slot
   always_comb begin
      pending   = (FIFO_CNT_W + 1)'(count)
                + (FIFO_CNT_W + 1)'(item_ff.valid && (item_ff.mode == MODE_TICK))
                + (FIFO_CNT_W + 1)'(sums.valid);
      req_ready = pending < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
      req_beat  = req_valid && req_ready;
      rsp_beat  = rsp_valid && rsp_ready;
   end

   // Register the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= req_beat;
      end
      if (req_beat) begin
         item_ff.mode      <= req_mode;
         item_ff.left_dir  <= req_left_dir;
         item_ff.right_dir <= req_right_dir;
      end
   end

   wsma_window u_window (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item_ff),
      .sums        (sums)
   );

   wsma_scale u_scale (
      .sums   (sums),
      .result (result)
   );

   wsma_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (sums.valid),
      .push_data (result),
      .pop       (rsp_beat),
      .head      (head),
      .count     (count)
   );

   assign rsp_valid       = count != '0;
   assign rsp_speed_left  = head.speed_left;
   assign rsp_speed_right = head.speed_right;
   assign rsp_speed_mean  = head.speed_mean;

endmodule

// File: rtl/wsma_checker.sv
// Port-level checks for the wheel speed meter, bound to the top level.
// Depends on wsma_pkg and wheel_speed_moving_average.
module wsma_checker import wsma_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [1:0]              req_mode,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_speed_left,
   input logic signed [OUT_W-1:0] rsp_speed_right,
   input logic signed [OUT_W-1:0] rsp_speed_mean
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Drop queued results on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result into an empty queue comes from an earlier accepted tick
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_mode == MODE_TICK, 3))
      else $error("result without a matching tick");

   // Two zero wheel speeds give a zero mean
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_left == '0 && rsp_speed_right == '0 |-> rsp_speed_mean == '0)
      else $error("nonzero mean of zero speeds");

endmodule

bind wheel_speed_moving_average wsma_checker u_wsma_checker (.*);
